// ----- rtl/tbfl_pkg.sv -----
// Shared types and constants for the triangle boundary face lookup block.
package tbfl_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;

  localparam int VC_W   = 11;
  localparam int EC_W   = 13;
  localparam int IDX_W  = 12;
  localparam int WT_W   = 32;
  localparam int ER_W   = 19;
  localparam int KEY_W  = 20;
  localparam int TR_W   = 28;
  localparam int ROW_W  = 13;
  localparam int VX_W   = 10;
  localparam int EA_W   = 12;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_EDGE   = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [1:0] COEF_POS  = 2'b01;
  localparam logic [1:0] COEF_NEG  = 2'b11;
  localparam logic [1:0] COEF_NONE = 2'b00;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_EDGE_COUNT   = 1'b1;

  typedef enum logic [1:0] {
    CMD_WEIGHT,
    CMD_EDGE,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  load_index;
    logic [WT_W-1:0]   vertex_weight;
    logic [ER_W-1:0]   edge_rank;
    logic [TR_W-1:0]   triangle_rank;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD1,
    S_PROD2,
    S_RANGE,
    S_WALK2,
    S_WALK1,
    S_WALK0,
    S_WREAD,
    S_WACC,
    S_FACE,
    S_BS,
    S_BSC,
    S_EMIT
  } state_t;

endpackage

// ----- rtl/tbfl_front.sv -----
// Input stage: accepts transfers; queues commands, drops unknown modes.
module tbfl_front (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tbfl_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                   in_tuser,
  input  logic                         q_full,
  output logic                         q_push,
  output tbfl_pkg::cmd_t               q_cmd
);

  always_comb begin
    q_cmd.load_index    = in_tdata[11:0];
    q_cmd.vertex_weight = in_tdata[43:12];
    q_cmd.edge_rank     = in_tdata[62:44];
    q_cmd.triangle_rank = in_tdata[90:63];
    case (in_tuser)
      tbfl_pkg::MODE_WEIGHT: q_cmd.kind = tbfl_pkg::CMD_WEIGHT;
      tbfl_pkg::MODE_EDGE:   q_cmd.kind = tbfl_pkg::CMD_EDGE;
      default:               q_cmd.kind = tbfl_pkg::CMD_QUERY;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full &&
                     (in_tuser == tbfl_pkg::MODE_WEIGHT ||
                      in_tuser == tbfl_pkg::MODE_EDGE ||
                      in_tuser == tbfl_pkg::MODE_QUERY);

endmodule

// ----- rtl/tbfl_queue.sv -----
// Two-entry command queue between the input stage and the execution engine.
module tbfl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tbfl_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tbfl_pkg::cmd_t head_cmd
);

  tbfl_pkg::cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = entry_r[rd_ptr_r];

endmodule

// ----- rtl/tbfl_back.sv -----
// Execution engine: table loads, triangle unranking, edge searches and result output.
module tbfl_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [12:0]                   cfg_wdata,
  input  logic                          q_valid,
  input  tbfl_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tbfl_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);

  localparam int NW = tbfl_pkg::VC_W;

  logic [tbfl_pkg::WT_W-1:0]  wmem [tbfl_pkg::MAX_VERTICES];
  logic [tbfl_pkg::KEY_W-1:0] emem [tbfl_pkg::MAX_EDGES];

  tbfl_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]                vc_r;
  logic [tbfl_pkg::EC_W-1:0]    ec_r;
  logic                         sorted_r, sorted_nxt;
  logic [tbfl_pkg::KEY_W-1:0]   prev_r, prev_nxt;
  logic [tbfl_pkg::TR_W-1:0]    r_r, r_nxt;
  logic [NW-1:0]                x_r, x_nxt;
  logic [tbfl_pkg::VX_W-1:0]    v0_r, v0_nxt, v1_r, v1_nxt, v2_r, v2_nxt;
  logic [1:0]                   k_r, k_nxt;
  logic [20:0]                  prod1_r, prod1_nxt;
  logic [30:0]                  prod2_r, prod2_nxt;
  logic [tbfl_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [tbfl_pkg::ROW_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [tbfl_pkg::WT_W-1:0]    w_r, w_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic                         ov_r, ov_nxt;
  logic [tbfl_pkg::OUT_DATA_W-1:0] od_r, od_nxt;
  logic [1:0]                   ou_r, ou_nxt;
  logic                         ol_r, ol_nxt;

  logic [tbfl_pkg::WT_W-1:0]    w_rd_r;
  logic [tbfl_pkg::KEY_W-1:0]   e_rd_r;
  logic                         w_we, e_we;
  logic [tbfl_pkg::VX_W-1:0]    w_waddr, w_raddr;
  logic [tbfl_pkg::EA_W-1:0]    e_waddr;
  logic [tbfl_pkg::KEY_W-1:0]   e_wdata;

  logic [NW-1:0]                n, m, vx;
  logic [tbfl_pkg::ROW_W-1:0]   len, mid;
  logic                         x_le_n, out_free, res_last;
  logic [21:0]                  mm, na, aa, key_full;
  logic [20:0]                  c2;
  logic [30:0]                  six_r;
  logic [tbfl_pkg::VX_W-1:0]    vclamp, fa, fb;
  logic [tbfl_pkg::KEY_W-1:0]   new_rank;
  logic [1:0]                   coef;

  always_comb begin
    n   = (vc_r > NW'(tbfl_pkg::MAX_VERTICES)) ? NW'(tbfl_pkg::MAX_VERTICES) : vc_r;
    len = (ec_r > tbfl_pkg::ROW_W'(tbfl_pkg::MAX_EDGES)) ?
          tbfl_pkg::ROW_W'(tbfl_pkg::MAX_EDGES) : ec_r;
    x_le_n = (x_r <= n);
    m      = n - x_r;
    mm     = {11'd0, m} * {11'd0, m - 11'd1};
    c2     = mm[21:1];
    six_r  = {1'b0, r_r, 2'b00} + {2'b00, r_r, 1'b0};
    vx     = x_r - 11'd1;
    vclamp = (vx > 11'd1023) ? 10'd1023 : vx[9:0];
    case (k_r)
      2'd0:    begin fa = v0_r; fb = v1_r; end
      2'd1:    begin fa = v0_r; fb = v2_r; end
      default: begin fa = v1_r; fb = v2_r; end
    endcase
    na       = {11'd0, n} * {12'd0, fa};
    aa       = {12'd0, fa} * ({12'd0, fa} + 22'd1);
    key_full = na - {1'b0, aa[21:1]} + {12'd0, fb} - {12'd0, fa} - 22'd1;
    mid      = lo_r + ((hi_r - lo_r) >> 1);
    out_free = !ov_r || out_tready;
    res_last = (status_r != tbfl_pkg::ST_OK) || (k_r == 2'd2);
    new_rank = {1'b0, q_cmd.edge_rank};
    case (k_r)
      2'd0:    w_raddr = v0_r;
      2'd1:    w_raddr = v1_r;
      default: w_raddr = v2_r;
    endcase
    if (status_r != tbfl_pkg::ST_OK) begin
      coef = tbfl_pkg::COEF_NONE;
    end else if (k_r == 2'd1) begin
      coef = tbfl_pkg::COEF_NEG;
    end else begin
      coef = tbfl_pkg::COEF_POS;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tbfl_pkg::S_IDLE: begin
        if (q_valid && q_cmd.kind == tbfl_pkg::CMD_QUERY) begin
          state_nxt = sorted_r ? tbfl_pkg::S_PROD1 : tbfl_pkg::S_EMIT;
        end
      end
      tbfl_pkg::S_PROD1: state_nxt = tbfl_pkg::S_PROD2;
      tbfl_pkg::S_PROD2: state_nxt = tbfl_pkg::S_RANGE;
      tbfl_pkg::S_RANGE: begin
        if (n < 11'd3 || six_r >= prod2_r) begin
          state_nxt = tbfl_pkg::S_EMIT;
        end else begin
          state_nxt = tbfl_pkg::S_WALK2;
        end
      end
      tbfl_pkg::S_WALK2: begin
        if (!(x_le_n && {7'd0, c2} <= r_r)) state_nxt = tbfl_pkg::S_WALK1;
      end
      tbfl_pkg::S_WALK1: begin
        if (!(x_le_n && {17'd0, m} <= r_r)) state_nxt = tbfl_pkg::S_WALK0;
      end
      tbfl_pkg::S_WALK0: begin
        if (!(x_le_n && r_r != '0)) state_nxt = tbfl_pkg::S_WREAD;
      end
      tbfl_pkg::S_WREAD: state_nxt = tbfl_pkg::S_WACC;
      tbfl_pkg::S_WACC: begin
        state_nxt = (k_r == 2'd2) ? tbfl_pkg::S_FACE : tbfl_pkg::S_WREAD;
      end
      tbfl_pkg::S_FACE: state_nxt = tbfl_pkg::S_BS;
      tbfl_pkg::S_BS: begin
        state_nxt = (lo_r < hi_r) ? tbfl_pkg::S_BSC : tbfl_pkg::S_EMIT;
      end
      tbfl_pkg::S_BSC: state_nxt = tbfl_pkg::S_BS;
      tbfl_pkg::S_EMIT: begin
        if (out_free) state_nxt = res_last ? tbfl_pkg::S_IDLE : tbfl_pkg::S_FACE;
      end
      default: state_nxt = tbfl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sorted_nxt = sorted_r;
    prev_nxt   = prev_r;
    r_nxt      = r_r;
    x_nxt      = x_r;
    v0_nxt     = v0_r;
    v1_nxt     = v1_r;
    v2_nxt     = v2_r;
    k_nxt      = k_r;
    prod1_nxt  = prod1_r;
    prod2_nxt  = prod2_r;
    key_nxt    = key_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    w_nxt      = w_r;
    status_nxt = status_r;
    ov_nxt     = ov_r && !out_tready;
    od_nxt     = od_r;
    ou_nxt     = ou_r;
    ol_nxt     = ol_r;
    q_pop      = 1'b0;
    w_we       = 1'b0;
    e_we       = 1'b0;
    w_waddr    = q_cmd.load_index[9:0];
    e_waddr    = q_cmd.load_index;
    e_wdata    = new_rank;
    case (state_r)
      tbfl_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            tbfl_pkg::CMD_WEIGHT: begin
              w_we = (q_cmd.load_index[11:10] == 2'b00);
            end
            tbfl_pkg::CMD_EDGE: begin
              e_we = 1'b1;
              if (new_rank < prev_r) sorted_nxt = 1'b0;
              prev_nxt = new_rank;
            end
            default: begin
              r_nxt      = q_cmd.triangle_rank;
              k_nxt      = 2'd0;
              lo_nxt     = '0;
              w_nxt      = '0;
              status_nxt = sorted_r ? tbfl_pkg::ST_OK : tbfl_pkg::ST_UNSORTED;
            end
          endcase
        end
      end
      tbfl_pkg::S_PROD1: prod1_nxt = 21'({11'd0, n} * {11'd0, n - 11'd1});
      tbfl_pkg::S_PROD2: prod2_nxt = 31'({11'd0, prod1_r} * {21'd0, n - 11'd2});
      tbfl_pkg::S_RANGE: begin
        x_nxt = 11'd1;
        if (n < 11'd3 || six_r >= prod2_r) status_nxt = tbfl_pkg::ST_RANGE;
      end
      tbfl_pkg::S_WALK2: begin
        x_nxt = x_r + 11'd1;
        if (x_le_n && {7'd0, c2} <= r_r) r_nxt = r_r - {7'd0, c2};
        else v0_nxt = vclamp;
      end
      tbfl_pkg::S_WALK1: begin
        x_nxt = x_r + 11'd1;
        if (x_le_n && {17'd0, m} <= r_r) r_nxt = r_r - {17'd0, m};
        else v1_nxt = vclamp;
      end
      tbfl_pkg::S_WALK0: begin
        x_nxt = x_r + 11'd1;
        if (x_le_n && r_r != '0) r_nxt = r_r - 28'd1;
        else v2_nxt = vclamp;
      end
      tbfl_pkg::S_WACC: begin
        if (k_r == 2'd0 || $signed(w_rd_r) > $signed(w_r)) w_nxt = w_rd_r;
        k_nxt = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      tbfl_pkg::S_FACE: begin
        key_nxt = key_full[19:0];
        lo_nxt  = '0;
        hi_nxt  = len;
      end
      tbfl_pkg::S_BS: mid_nxt = mid;
      tbfl_pkg::S_BSC: begin
        if (e_rd_r < key_r) lo_nxt = mid_r + 13'd1;
        else hi_nxt = mid_r;
      end
      tbfl_pkg::S_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = {1'b0, w_r, coef, lo_r};
          ou_nxt = status_r;
          ol_nxt = res_last;
          k_nxt  = k_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tbfl_pkg::S_IDLE;
      vc_r     <= 11'd3;
      ec_r     <= '0;
      sorted_r <= 1'b1;
      prev_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sorted_r <= sorted_nxt;
      prev_r   <= prev_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we && cfg_addr == tbfl_pkg::REG_VERTEX_COUNT) vc_r <= cfg_wdata[10:0];
      if (cfg_we && cfg_addr == tbfl_pkg::REG_EDGE_COUNT) ec_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    r_r      <= r_nxt;
    x_r      <= x_nxt;
    v0_r     <= v0_nxt;
    v1_r     <= v1_nxt;
    v2_r     <= v2_nxt;
    k_r      <= k_nxt;
    prod1_r  <= prod1_nxt;
    prod2_r  <= prod2_nxt;
    key_r    <= key_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    w_r      <= w_nxt;
    status_r <= status_nxt;
    od_r     <= od_nxt;
    ou_r     <= ou_nxt;
    ol_r     <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= q_cmd.vertex_weight;
    w_rd_r <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    e_rd_r <= emem[mid[11:0]];
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

endmodule

// ----- rtl/triangle_boundary_face_lookup_core.sv -----
// Top level of the triangle boundary face lookup block.
//
// The input stream carries load and query commands; in_tuser selects the kind.
// A vertex weight or edge rank load gives no result. A query unranks the
// triangle by stepping over vertex positions, one binomial compare per cycle,
// reads three weights in the WREAD and WACC states, then runs one binary search
// per edge, each probe taking a BS and a BSC state over the edge table memory.
// A query emits three transfers, the last with out_tlast set; an unsorted table or
// an out-of-range rank gives a single transfer with a nonzero status in out_tuser.
// A two-entry command queue lets the input side keep accepting while the
// engine waits on a stalled output; when the queue is full, in_tready drops.
// Synchronous active-low reset clears the control state, sets vertex_count to 3,
// edge_count to 0 and marks the edge table sorted; the tables keep contents. The
// user writes configuration via cfg_we only while idle, unenforced by the block.
module triangle_boundary_face_lookup_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // load_index, vertex_weight, edge_rank, triangle_rank
  input  logic [95:0] in_tdata,
  // mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // row_index, coefficient, column_weight
  output logic [47:0] out_tdata,
  // status
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  tbfl_pkg::cmd_t push_cmd, head_cmd;
  logic           q_full, q_push, q_pop, q_valid;

  tbfl_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tbfl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  tbfl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/tbfl_checker.sv -----
// Port-level checker for the triangle boundary face lookup block, with its bind.
module tbfl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tlast && out_tdata == 48'd0)
    else $error("error result not a lone zero transfer");

  a_coef: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == 2'd0 |->
      (out_tdata[14:13] == 2'b01 || out_tdata[14:13] == 2'b11))
    else $error("bad coefficient on a normal result");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind triangle_boundary_face_lookup_core tbfl_checker u_tbfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/tb_triangle_boundary_face_lookup_core.sv -----
// Self-checking testbench for the triangle boundary face lookup core.
module tb_triangle_boundary_face_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam int QUIET_CYCLES = 1500;
  localparam int STALL_LIMIT  = 20000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 30;
  localparam int NV_PRE       = 48;
  localparam int NE_PRE       = 96;

  typedef struct packed {
    logic [tbfl_pkg::ROW_W-1:0] row;
    logic [1:0]                 coef;
    logic [tbfl_pkg::WT_W-1:0]  weight;
    logic [1:0]                 status;
    logic                       last;
  } face_t;

  typedef struct {
    logic [1:0]                 mode;
    logic [tbfl_pkg::IDX_W-1:0] idx;
    logic [tbfl_pkg::WT_W-1:0]  weight;
    logic [tbfl_pkg::ER_W-1:0]  erank;
    logic [tbfl_pkg::TR_W-1:0]  trank;
    bit                         typed;
    logic [1:0]                 status;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  triangle_boundary_face_lookup_core dut (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic [tbfl_pkg::WT_W-1:0] weight_mem [tbfl_pkg::MAX_VERTICES];
  logic [tbfl_pkg::ER_W-1:0] edge_mem [tbfl_pkg::MAX_EDGES];
  bit                        table_sorted_q = 1'b1;
  logic [tbfl_pkg::ER_W-1:0] last_edge_rank = '0;
  longint                    vertex_count_q = 3;
  longint                    edge_count_q = 0;

  face_t expected_faces[$];
  int    errors = 0;
  int    items_sent = 0;
  int    queries_sent = 0;
  int    faces_seen = 0;
  int    send_idle = 0;
  int    recv_idle = 0;
  bit    in_fire = 1'b0;
  bit    out_fire = 1'b0;
  int    quiet_count = 0;

  function automatic void add_face(face_t f);
    expected_faces.insert(expected_faces.size(), f);
  endfunction

  function automatic longint binom(longint m, int k);
    if (k == 0) return 1;
    if (k == 1) return m;
    if (k == 2) return (m < 2) ? 0 : m * (m - 1) / 2;
    if (m < 3) return 0;
    return m * (m - 1) / 2 * (m - 2) / 3;
  endfunction

  function automatic longint first_not_below(longint key, longint len);
    longint lo, hi, mid;
    lo = 0;
    hi = len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (longint'(edge_mem[mid]) < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [tbfl_pkg::WT_W-1:0] wmax(logic [tbfl_pkg::WT_W-1:0] x,
                                                      logic [tbfl_pkg::WT_W-1:0] y);
    return ($signed(x) >= $signed(y)) ? x : y;
  endfunction

  function automatic void predict_faces(logic [1:0] mode, logic [tbfl_pkg::IDX_W-1:0] idx,
                                        logic [tbfl_pkg::WT_W-1:0] wt,
                                        logic [tbfl_pkg::ER_W-1:0] er,
                                        logic [tbfl_pkg::TR_W-1:0] tr);
    longint n, len, r, x, c;
    longint v[3];
    longint key[3];
    logic [tbfl_pkg::WT_W-1:0] w;
    face_t f;
    if (mode == tbfl_pkg::MODE_WEIGHT) begin
      if (idx < tbfl_pkg::MAX_VERTICES) weight_mem[idx] = wt;
      return;
    end
    if (mode == tbfl_pkg::MODE_EDGE) begin
      if (er < last_edge_rank) table_sorted_q = 1'b0;
      last_edge_rank = er;
      edge_mem[idx] = er;
      return;
    end
    if (mode != tbfl_pkg::MODE_QUERY) return;
    if (!table_sorted_q) begin
      add_face('{'0, tbfl_pkg::COEF_NONE, '0, tbfl_pkg::ST_UNSORTED, 1'b1});
      return;
    end
    n = (vertex_count_q > tbfl_pkg::MAX_VERTICES) ? tbfl_pkg::MAX_VERTICES : vertex_count_q;
    len = (edge_count_q > tbfl_pkg::MAX_EDGES) ? tbfl_pkg::MAX_EDGES : edge_count_q;
    r = tr;
    if (r >= binom(n, 3)) begin
      add_face('{'0, tbfl_pkg::COEF_NONE, '0, tbfl_pkg::ST_RANGE, 1'b1});
      return;
    end
    x = 1;
    for (int i = 1; i <= 3; i++) begin
      while (x <= n) begin
        c = binom(n - x, 3 - i);
        if (r < c) break;
        r -= c;
        x++;
      end
      v[i-1] = x - 1;
      x++;
    end
    for (int i = 0; i < 3; i++)
      if (v[i] >= tbfl_pkg::MAX_VERTICES) v[i] = tbfl_pkg::MAX_VERTICES - 1;
    key[0] = n * v[0] - v[0] * (v[0] + 1) / 2 + v[1] - v[0] - 1;
    key[1] = n * v[0] - v[0] * (v[0] + 1) / 2 + v[2] - v[0] - 1;
    key[2] = n * v[1] - v[1] * (v[1] + 1) / 2 + v[2] - v[1] - 1;
    w = wmax(weight_mem[v[0]], wmax(weight_mem[v[1]], weight_mem[v[2]]));
    for (int k = 0; k < 3; k++) begin
      f.row = tbfl_pkg::ROW_W'(first_not_below(key[k], len));
      f.coef = (k == 1) ? tbfl_pkg::COEF_NEG : tbfl_pkg::COEF_POS;
      f.weight = w;
      f.status = tbfl_pkg::ST_OK;
      f.last = (k == 2);
      add_face(f);
    end
  endfunction

  task automatic send_item(logic [1:0] mode, logic [tbfl_pkg::IDX_W-1:0] idx,
                           logic [tbfl_pkg::WT_W-1:0] wt, logic [tbfl_pkg::ER_W-1:0] er,
                           logic [tbfl_pkg::TR_W-1:0] tr,
                           bit typed = 1'b0, logic [1:0] status = tbfl_pkg::ST_OK);
    bit ok;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {5'b0, tr, er, wt, idx};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    items_sent++;
    if (mode == tbfl_pkg::MODE_QUERY) queries_sent++;
    if (typed) add_face('{'0, tbfl_pkg::COEF_NONE, '0, status, 1'b1});
    else predict_faces(mode, idx, wt, er, tr);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_faces.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(int vc, int ec);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= tbfl_pkg::REG_VERTEX_COUNT;
    cfg_wdata <= 13'(vc);
    @(posedge clk);
    cfg_addr <= tbfl_pkg::REG_EDGE_COUNT;
    cfg_wdata <= 13'(ec);
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_count_q = vc & 32'h7FF;
    edge_count_q = ec & 32'h1FFF;
  endtask

  // Only preloaded vertices may be touched, so large vertex counts use low ranks,
  // which give the triangles {0, 1, 2 + rank}.
  task automatic random_item();
    longint n, c, hi;
    int pick;
    n = (vertex_count_q > tbfl_pkg::MAX_VERTICES) ? tbfl_pkg::MAX_VERTICES : vertex_count_q;
    c = binom(n, 3);
    hi = (n > NV_PRE) ? NV_PRE - 3 : c - 1;
    pick = $urandom_range(99);
    if (pick < 8)
      send_item(tbfl_pkg::MODE_WEIGHT, tbfl_pkg::IDX_W'($urandom), $urandom,
                tbfl_pkg::ER_W'($urandom), tbfl_pkg::TR_W'($urandom));
    else if (pick < 12)
      send_item(MODE_UNKNOWN, tbfl_pkg::IDX_W'($urandom), $urandom,
                tbfl_pkg::ER_W'($urandom), tbfl_pkg::TR_W'($urandom));
    else if (pick < 20 || c == 0)
      send_item(tbfl_pkg::MODE_QUERY, tbfl_pkg::IDX_W'($urandom), $urandom,
                tbfl_pkg::ER_W'($urandom), tbfl_pkg::TR_W'($urandom));
    else
      send_item(tbfl_pkg::MODE_QUERY, tbfl_pkg::IDX_W'($urandom), $urandom,
                tbfl_pkg::ER_W'($urandom),
                tbfl_pkg::TR_W'($urandom_range(0, 32'(hi))));
  endtask

  // Output checking, sampled at the falling edge where everything is settled.
  always @(negedge clk) begin
    face_t got, want;
    in_fire = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (out_fire) begin
      got = {out_tdata[12:0], out_tdata[14:13], out_tdata[46:15], out_tuser, out_tlast};
      faces_seen++;
      if (expected_faces.size() == 0) begin
        errors++;
        $display("%0t: expected no transfer, actual %h", $time, got);
      end else begin
        want = expected_faces.pop_front();
        if (got.row !== want.row) begin
          errors++;
          $display("%0t: row_index expected %0d actual %0d", $time, want.row, got.row);
        end
        if (got.coef !== want.coef) begin
          errors++;
          $display("%0t: coefficient expected %b actual %b", $time, want.coef, got.coef);
        end
        if (got.weight !== want.weight) begin
          errors++;
          $display("%0t: column_weight expected %h actual %h", $time, want.weight,
                   got.weight);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
    if (in_fire || out_fire) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
    if (quiet_count >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_triangle_boundary_face_lookup_core: done, errors");
      $finish;
    end
  end

  row_t directed[] = '{
    '{tbfl_pkg::MODE_WEIGHT, 12'd0, 32'h8000_0000, '0, '0, 1'b0, tbfl_pkg::ST_OK},
    '{tbfl_pkg::MODE_WEIGHT, 12'd1, 32'h7FFF_FFFF, '0, '0, 1'b0, tbfl_pkg::ST_OK},
    '{tbfl_pkg::MODE_WEIGHT, 12'd2, 32'h0000_0000, '0, '0, 1'b0, tbfl_pkg::ST_OK},
    '{tbfl_pkg::MODE_QUERY,  12'd0, '0, '0, 28'd0, 1'b0, tbfl_pkg::ST_OK},
    '{tbfl_pkg::MODE_WEIGHT, 12'd4095, 32'hFFFF_FFFF, '0, '0, 1'b0, tbfl_pkg::ST_OK},
    '{MODE_UNKNOWN, 12'hFFF, 32'hFFFF_FFFF, 19'h7FFFF, 28'hFFFFFFF, 1'b0, tbfl_pkg::ST_OK},
    '{tbfl_pkg::MODE_QUERY,  12'd0, '0, '0, 28'd1, 1'b1, tbfl_pkg::ST_RANGE},
    '{tbfl_pkg::MODE_QUERY,  12'hFFF, '0, '0, 28'hFFFFFFF, 1'b1, tbfl_pkg::ST_RANGE},
    '{tbfl_pkg::MODE_WEIGHT, 12'd1, 32'hFFFF_FFFF, '0, '0, 1'b0, tbfl_pkg::ST_OK},
    '{tbfl_pkg::MODE_QUERY,  12'd0, '0, '0, 28'd0, 1'b0, tbfl_pkg::ST_OK},
    '{tbfl_pkg::MODE_WEIGHT, 12'd1024, 32'h1234_5678, '0, '0, 1'b0, tbfl_pkg::ST_OK}
  };

  int vc_list[PHASES] = '{4, 10, 48, 2047, 0, 40, 20, 2};
  int ec_list[PHASES] = '{1, 50, 96, 60, 5, 96, 0, 8191};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 10;
    recv_idle = 46;
    for (int i = 0; i < NV_PRE; i++)
      send_item(tbfl_pkg::MODE_WEIGHT, tbfl_pkg::IDX_W'(i), $urandom, '0, '0);
    // Non-decreasing ranks with occasional repeats keep the table sorted.
    for (int i = 0; i < NE_PRE; i++)
      send_item(tbfl_pkg::MODE_EDGE, tbfl_pkg::IDX_W'(i), '0,
                tbfl_pkg::ER_W'(i * 12 + $urandom_range(0, 12)), '0);
    foreach (directed[i])
      send_item(directed[i].mode, directed[i].idx, directed[i].weight, directed[i].erank,
                directed[i].trank, directed[i].typed, directed[i].status);
    for (int p = 0; p < PHASES; p++) begin
      set_config(vc_list[p], ec_list[p]);
      send_idle = (p < 3) ? 10 : (p < 6) ? 46 : 0;
      recv_idle = (p < 3) ? 46 : (p < 6) ? 10 : 0;
      repeat (PHASE_ITEMS) random_item();
    end
    set_config(10, 50);
    send_item(tbfl_pkg::MODE_EDGE, 12'd4095, '0, 19'd523775, '0);
    send_item(tbfl_pkg::MODE_QUERY, '0, '0, '0, 28'd5);
    send_item(tbfl_pkg::MODE_EDGE, 12'd0, '0, 19'd0, '0);
    send_item(tbfl_pkg::MODE_QUERY, '0, '0, '0, 28'd5, 1'b1, tbfl_pkg::ST_UNSORTED);
    send_item(tbfl_pkg::MODE_QUERY, '0, '0, '0, 28'hFFFFFFF, 1'b1, tbfl_pkg::ST_UNSORTED);
    repeat (10) random_item();
    drain();
    $display("covered %0d input transfers (%0d queries) and %0d result transfers",
             items_sent, queries_sent, faces_seen);
    $display("over %0d register settings, with and without stalls", PHASES + 2);
    if (errors == 0) begin
      $display("tb_triangle_boundary_face_lookup_core: done, clean");
    end else begin
      $display("tb_triangle_boundary_face_lookup_core: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tbfl_pkg.sv
rtl/tbfl_front.sv
rtl/tbfl_queue.sv
rtl/tbfl_back.sv
rtl/triangle_boundary_face_lookup_core.sv
rtl/tbfl_checker.sv
tb/tb_triangle_boundary_face_lookup_core.sv
